/* sv/rre_pkg.sv */
// Shared types, constants and register codes for the raster RLE pixel decoder.
`timescale 1ns / 1ps

package rre_pkg;

    localparam int DEF_MAX_WIDTH  = 8192;
    localparam int DEF_MAX_HEIGHT = 8192;
    localparam int MAX_RESULTS    = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RLE_ENABLED  = 3'd0,
        REG_DEPTH_MODE   = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_ESCAPE_CODE  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        DEPTH_1BIT  = 2'd0,
        DEPTH_8BIT  = 2'd1,
        DEPTH_24BIT = 2'd2,
        DEPTH_32BIT = 2'd3
    } t_depth;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_COUNT  = 2'd1,
        PH_VALUE  = 2'd2
    } t_phase;

    // One packed result word
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        eoi;
    } t_word;

    typedef struct packed {
        logic  valid;
        t_word w;
    } t_emit_req;

    // Packer command: one byte or one flush per cycle
    typedef struct packed {
        logic       put;
        logic       flush;
        logic       last;
        logic [7:0] data;
    } t_pack_cmd;

    typedef struct packed {
        logic held_go;
        logic step_end;
    } t_emit_ctl;

    typedef struct packed {
        logic rdy;
        logic end_rdy;
        logic held_valid;
    } t_emit_sts;

endpackage

/* sv/rre_ifs.sv */
// Handshake interfaces for the byte input, result output and register write channels.
`timescale 1ns / 1ps

interface rre_byte_if import rre_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

interface rre_word_if import rre_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;
    logic        last_of_run;
    logic        end_of_image;

    modport source (output valid, output out_bytes, output byte_count,
                    output last_of_run, output end_of_image, input ready);
    modport sink   (input valid, input out_bytes, input byte_count,
                    input last_of_run, input end_of_image, output ready);
endinterface

interface rre_cfg_if import rre_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/rre_pack.sv */
// Byte packer: takes one byte or a flush per cycle while i_adv is high and builds words of up to four bytes.
`timescale 1ns / 1ps

module rre_pack import rre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pack_cmd i_cmd,
    input  logic      i_adv,
    output t_emit_req o_req
);

    logic [23:0] r_buf, n_buf;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] merged;

    assign merged = {8'd0, r_buf} | (32'(i_cmd.data) << {r_cnt, 3'b000});

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        o_req = '0;
        if (i_cmd.put && i_adv) begin
            if (r_cnt == 2'd3) begin
                o_req.valid   = 1'b1;
                o_req.w.word  = merged;
                o_req.w.count = 3'd4;
                o_req.w.eoi   = i_cmd.last;
                n_buf = '0;
                n_cnt = '0;
            end else if (i_cmd.last) begin
                o_req.valid   = 1'b1;
                o_req.w.word  = merged;
                o_req.w.count = {1'b0, r_cnt} + 3'd1;
                o_req.w.eoi   = 1'b1;
                n_buf = '0;
                n_cnt = '0;
            end else begin
                n_buf = merged[23:0];
                n_cnt = r_cnt + 2'd1;
            end
        end else if (i_cmd.flush && i_adv) begin
            // drop nothing: a partial word leaves marked as image end
            if (r_cnt != 2'd0) begin
                o_req.valid   = 1'b1;
                o_req.w.word  = {8'd0, r_buf};
                o_req.w.count = {1'b0, r_cnt};
                o_req.w.eoi   = 1'b1;
            end
            n_buf = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/rre_emit.sv */
// Result queue: one-word lookahead to mark the last word of a transaction, cap and held word.
`timescale 1ns / 1ps

module rre_emit import rre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_emit_req   i_req,
    input  t_emit_ctl   i_ctl,
    output t_emit_sts   o_sts,
    rre_word_if.source  o_word
);

    localparam int CW = $clog2(MAX_RESULTS + 1);

    logic [CW-1:0] r_cnt;
    logic          r_pv, r_hv, r_ov, r_out_last;
    t_word         r_pend, r_held, r_out, src;
    logic          out_free, at_cap, rdy, end_rdy, take, load_out;

    assign out_free = !r_ov || o_word.ready;
    assign at_cap   = (r_cnt == CW'(MAX_RESULTS));
    assign rdy      = at_cap || !r_pv || out_free;
    assign end_rdy  = !r_pv || out_free;
    assign src      = i_ctl.held_go ? r_held : i_req.w;
    assign take     = (i_req.valid || i_ctl.held_go) && rdy;
    // advance the pending word into the output register
    assign load_out = take ? (!at_cap && r_pv) : (i_ctl.step_end && end_rdy && r_pv);

    assign o_sts.rdy        = rdy;
    assign o_sts.end_rdy    = end_rdy;
    assign o_sts.held_valid = r_hv;

    assign o_word.valid        = r_ov;
    assign o_word.out_bytes    = r_out.word;
    assign o_word.byte_count   = r_out.count;
    assign o_word.last_of_run  = r_out_last;
    assign o_word.end_of_image = r_out.eoi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
            r_hv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_word.ready) begin
                r_ov <= 1'b0;
            end
            if (take) begin
                if (i_ctl.held_go) begin
                    r_hv <= 1'b0;
                end else if (at_cap) begin
                    r_hv <= 1'b1;
                end
                if (!at_cap) begin
                    r_pv  <= 1'b1;
                    r_cnt <= r_cnt + CW'(1);
                end
            end else if (i_ctl.step_end && end_rdy) begin
                if (r_pv) begin
                    r_pv <= 1'b0;
                end
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (!at_cap) begin
                if (r_pv) begin
                    r_out      <= r_pend;
                    r_out_last <= 1'b0;
                end
                r_pend <= src;
            end else begin
                r_held <= src;
            end
        end else if (i_ctl.step_end && end_rdy && r_pv) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RESULTS))
        else $error("result count past cap");

    a_cnt_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_pv)
        else $error("results counted but no pending word");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step_end && end_rdy && !take) |=> (!r_pv && r_cnt == '0))
        else $error("transaction close left pending state");

endmodule

/* sv/raster_rle_pixel_decoder.sv */
// Top level: run-length decode, line and pixel tracking, sequencer around the shared packer.
// Per raw byte the sequencer steps through: accept, held word replay (if any), one feed per
//   decoded byte (1, or count+1 for a run), one put per output byte, image-end flush (if any),
//   close. The single packer takes one byte a cycle while the result queue is ready.
// The last result of a byte is in the output register the cycle after the close step.
// Output stalls hold the packer and sequencer; the input is not ready until the byte is done.
// Reset (synchronous, active low) clears sequencer, line position, packer and result queue and
//   loads the register defaults; no memory, so no clearing pass.
`timescale 1ns / 1ps

module raster_rle_pixel_decoder import rre_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rre_cfg_if.sink    i_cfg,
    rre_byte_if.sink   i_byte,
    rre_word_if.source o_word
);

    // Widths follow the size bounds
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int HCW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int LLW = WW + 2;
    // Reciprocal of three for the byte-in-pixel index
    localparam int S3  = LLW + 2;
    localparam int PW  = LLW + S3;
    localparam logic [S3-1:0] K3 = S3'((2 ** S3) / 3);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HELD  = 6'b000010,
        S_FEED  = 6'b000100,
        S_PUT   = 6'b001000,
        S_FLUSH = 6'b010000,
        S_END   = 6'b100000
    } t_state;

    // Registers and their next values
    t_state          r_state, n_state;
    logic            r_rle, n_rle;
    t_depth          r_depth, n_depth;
    logic [13:0]     r_width, n_width;
    logic [13:0]     r_height, n_height;
    logic [7:0]      r_esc, n_esc;
    t_phase          r_phase, n_phase;
    logic [7:0]      r_run, n_run;
    logic [7:0]      r_val, n_val;
    logic            r_do_feed, n_do_feed;
    logic [LLW-1:0]  r_pos, n_pos;
    logic [HW-1:0]   r_line, n_line;
    logic [31:0]     r_stage, n_stage;
    logic [23:0]     r_putw, n_putw;
    logic [1:0]      r_put_n, n_put_n;
    logic [1:0]      r_put_i, n_put_i;
    logic            r_put_final, n_put_final;
    logic            r_img_end, n_img_end;

    logic            in_acc;
    logic [WCW-1:0]  w_ext;
    logic [HCW-1:0]  h_ext;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [LLW-1:0]  w_l, ll, len_total, pos_n;
    logic [HW-1:0]   line_n;
    logic            last_line, in_data, line_end, img_end, final_b;
    logic [PW-1:0]   m3_prod;
    logic [LLW-1:0]  m3_q;
    logic [2:0]      m3_r;
    logic [1:0]      k3, k, k_last;
    logic            is_multi;
    logic [31:0]     b_sh, ns;
    logic [1:0]      put_n_c;
    logic [23:0]     putw_c;

    t_pack_cmd       pack_cmd;
    t_emit_req       emit_req;
    t_emit_ctl       emit_ctl;
    t_emit_sts       emit_sts;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = (r_state == S_IDLE);
    assign in_acc       = i_byte.valid && i_byte.ready;

    // Clamp sizes: zero counts as one, large values stop at the bound
    assign w_ext = WCW'(r_width);
    assign h_ext = HCW'(r_height);
    always_comb begin
        if (r_width == 14'd0) begin
            w_eff = WW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext[WW-1:0];
        end
        if (r_height == 14'd0) begin
            h_eff = HW'(1);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext[HW-1:0];
        end
    end

    // pos mod 3: multiply by the reciprocal, then one correction step
    assign m3_prod = PW'(r_pos) * PW'(K3);
    assign m3_q    = m3_prod[S3 +: LLW];
    assign m3_r    = r_pos[2:0] - {m3_q[1:0], 1'b0} - m3_q[2:0];
    assign k3      = (m3_r >= 3'd3) ? 2'(m3_r - 3'd3) : m3_r[1:0];

    // Line length and the byte's place within its pixel
    assign w_l = LLW'(w_eff);
    always_comb begin
        unique case (r_depth)
            DEPTH_1BIT: begin
                ll = (w_l + LLW'(7)) >> 3;
                k = 2'd0; k_last = 2'd0; is_multi = 1'b0;
            end
            DEPTH_8BIT: begin
                ll = w_l;
                k = 2'd0; k_last = 2'd0; is_multi = 1'b0;
            end
            DEPTH_24BIT: begin
                ll = (w_l << 1) + w_l;
                k = k3; k_last = 2'd2; is_multi = 1'b1;
            end
            DEPTH_32BIT: begin
                ll = w_l << 2;
                k = r_pos[1:0]; k_last = 2'd3; is_multi = 1'b1;
            end
        endcase
    end

    assign len_total = ll + LLW'(ll[0]);
    assign pos_n     = r_pos + LLW'(1);
    assign line_n    = r_line + HW'(1);
    assign last_line = (line_n >= h_eff);
    assign in_data   = (r_pos < ll);
    assign line_end  = (pos_n >= len_total);
    assign img_end   = line_end && last_line;
    assign final_b   = last_line && (pos_n == ll);

    // Pixel staging: first byte of a pixel restarts the stage
    assign b_sh = 32'(r_val) << {k, 3'b000};
    assign ns   = (k == 2'd0) ? b_sh : (r_stage | b_sh);

    // Bytes to hand the packer, first one in the low byte; pad and alpha drop out
    always_comb begin
        put_n_c = 2'd0;
        putw_c  = '0;
        if (in_data) begin
            if (!is_multi) begin
                put_n_c = 2'd1;
                putw_c  = {16'd0, r_val};
            end else if (k == k_last) begin
                put_n_c = 2'd3;
                if (r_depth == DEPTH_24BIT) begin
                    putw_c = {ns[7:0], ns[15:8], ns[23:16]};
                end else begin
                    putw_c = {ns[15:8], ns[23:16], ns[31:24]};
                end
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rle       = r_rle;
        n_depth     = r_depth;
        n_width     = r_width;
        n_height    = r_height;
        n_esc       = r_esc;
        n_phase     = r_phase;
        n_run       = r_run;
        n_val       = r_val;
        n_do_feed   = r_do_feed;
        n_pos       = r_pos;
        n_line      = r_line;
        n_stage     = r_stage;
        n_putw      = r_putw;
        n_put_n     = r_put_n;
        n_put_i     = r_put_i;
        n_put_final = r_put_final;
        n_img_end   = r_img_end;
        pack_cmd    = '0;
        emit_ctl    = '0;

        if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_RLE_ENABLED:  n_rle    = i_cfg.data[0];
                REG_DEPTH_MODE:   n_depth  = t_depth'(i_cfg.data[1:0]);
                REG_IMAGE_WIDTH:  n_width  = i_cfg.data;
                REG_IMAGE_HEIGHT: n_height = i_cfg.data;
                REG_ESCAPE_CODE:  n_esc    = i_cfg.data[7:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_do_feed = 1'b0;
                    n_val     = i_byte.raw_byte;
                    if (!r_rle) begin
                        n_phase   = PH_NORMAL;
                        n_do_feed = 1'b1;
                        n_run     = '0;
                    end else begin
                        unique case (r_phase)
                            PH_NORMAL: begin
                                if (i_byte.raw_byte == r_esc) begin
                                    n_phase = PH_COUNT;
                                end else begin
                                    n_do_feed = 1'b1;
                                    n_run     = '0;
                                end
                            end
                            PH_COUNT: begin
                                if (i_byte.raw_byte == 8'd0) begin
                                    // escaped literal escape byte
                                    n_phase   = PH_NORMAL;
                                    n_do_feed = 1'b1;
                                    n_val     = r_esc;
                                    n_run     = '0;
                                end else begin
                                    n_run   = i_byte.raw_byte;
                                    n_phase = PH_VALUE;
                                end
                            end
                            PH_VALUE: begin
                                // run value: keep the count for the repeat loop
                                n_phase   = PH_NORMAL;
                                n_do_feed = 1'b1;
                            end
                            default: n_phase = PH_NORMAL;
                        endcase
                    end
                    if (emit_sts.held_valid) begin
                        n_state = S_HELD;
                    end else if (n_do_feed) begin
                        n_state = S_FEED;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_HELD: begin
                // replay the word held back by the cap as first result
                emit_ctl.held_go = 1'b1;
                if (emit_sts.rdy) begin
                    n_state = r_do_feed ? S_FEED : S_END;
                end
            end
            S_FEED: begin
                if (in_data && is_multi) begin
                    n_stage = ns;
                end
                n_put_n     = put_n_c;
                n_putw      = putw_c;
                n_put_final = final_b;
                n_put_i     = '0;
                n_img_end   = img_end;
                if (img_end) begin
                    // image done: restart, rest of the run is discarded
                    n_pos   = '0;
                    n_line  = '0;
                    n_stage = '0;
                    n_run   = '0;
                    n_phase = PH_NORMAL;
                end else if (line_end) begin
                    n_pos  = '0;
                    n_line = line_n;
                end else begin
                    n_pos = pos_n;
                end
                if (put_n_c != 2'd0) begin
                    n_state = S_PUT;
                end else if (img_end) begin
                    n_state = S_FLUSH;
                end else if (r_run != 8'd0) begin
                    n_run   = r_run - 8'd1;
                    n_state = S_FEED;
                end else begin
                    n_state = S_END;
                end
            end
            S_PUT: begin
                pack_cmd.put  = 1'b1;
                pack_cmd.data = r_putw[{r_put_i, 3'b000} +: 8];
                pack_cmd.last = r_put_final && (r_put_i == r_put_n - 2'd1);
                if (emit_sts.rdy) begin
                    if (r_put_i == r_put_n - 2'd1) begin
                        if (r_img_end) begin
                            n_state = S_FLUSH;
                        end else if (r_run != 8'd0) begin
                            n_run   = r_run - 8'd1;
                            n_state = S_FEED;
                        end else begin
                            n_state = S_END;
                        end
                    end else begin
                        n_put_i = r_put_i + 2'd1;
                    end
                end
            end
            S_FLUSH: begin
                pack_cmd.flush = 1'b1;
                if (emit_sts.rdy) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                // close the transaction: last pending word goes out marked
                emit_ctl.step_end = 1'b1;
                if (emit_sts.end_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rle     <= 1'b0;
            r_depth   <= DEPTH_8BIT;
            r_width   <= 14'd1;
            r_height  <= 14'd1;
            r_esc     <= 8'd128;
            r_phase   <= PH_NORMAL;
            r_run     <= '0;
            r_do_feed <= 1'b0;
            r_pos     <= '0;
            r_line    <= '0;
            r_stage   <= '0;
            r_put_n   <= '0;
            r_put_i   <= '0;
            r_img_end <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rle     <= n_rle;
            r_depth   <= n_depth;
            r_width   <= n_width;
            r_height  <= n_height;
            r_esc     <= n_esc;
            r_phase   <= n_phase;
            r_run     <= n_run;
            r_do_feed <= n_do_feed;
            r_pos     <= n_pos;
            r_line    <= n_line;
            r_stage   <= n_stage;
            r_put_n   <= n_put_n;
            r_put_i   <= n_put_i;
            r_img_end <= n_img_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_putw      <= n_putw;
        r_put_final <= n_put_final;
    end

    rre_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pack_cmd),
        .i_adv   (emit_sts.rdy),
        .o_req   (emit_req)
    );

    rre_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .i_ctl   (emit_ctl),
        .o_sts   (emit_sts),
        .o_word  (o_word)
    );

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("input taken but sequencer stayed idle");

    a_put_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_put_i < r_put_n))
        else $error("packer index past byte list");

    a_held_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HELD) |-> emit_sts.held_valid)
        else $error("held replay without held word");

endmodule
